>>> rtl/alternating_bit_receiver_unit_macros.svh
// Assertion macros for the alternating-bit receiver.
// Used by the top level only; depends on a clock named clk and a reset named rst.
`ifndef ALTERNATING_BIT_RECEIVER_UNIT_MACROS_SVH
`define ALTERNATING_BIT_RECEIVER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ABR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("abr: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define ABR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("abr: next-cycle check failed");

`endif

>>> rtl/abr_pkg.sv
// Shared types and constants of the alternating-bit receiver.
// No dependencies; imported by every module of the block.
package abr_pkg;

  // Packet geometry and the ack number an accepted packet must carry.
  localparam int PAYLOAD_LEN  = 20;
  localparam int REQUIRED_ACK = 0;
  localparam int POS_W        = $clog2(PAYLOAD_LEN);
  localparam int WT_W         = $clog2(PAYLOAD_LEN + 1);
  localparam int PROD_W       = 8 + WT_W + 1;

  // Depth of the job queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Checksum weights of the header fields.
  localparam logic [31:0] ACK_WEIGHT = 32'd21;
  localparam logic [31:0] SEQ_WEIGHT = 32'd22;

  // Weighted sums of the reply patterns.
  localparam int          REPLY_LEN     = 19;
  localparam int          REPLY_WT_SUM  = REPLY_LEN * (REPLY_LEN + 1) / 2;
  localparam logic [31:0] ONES_PAT_SUM  = 32'(49 * REPLY_WT_SUM);
  localparam logic [31:0] ZEROS_PAT_SUM = 32'(48 * REPLY_WT_SUM);
  localparam logic [31:0] DUP_PAT_SUM   = 32'(68 * 1 + 85 * 2 + 80 * 3);

  // Result kind codes.
  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_REPLY = 1'b1;

  // Reply pattern codes.
  localparam logic [1:0] PAT_ONES  = 2'd0;
  localparam logic [1:0] PAT_DUP   = 2'd1;
  localparam logic [1:0] PAT_ZEROS = 2'd2;

  // Outcome of classifying one packet.
  typedef enum logic [2:0] {
    JOB_ACCEPT = 3'b001,
    JOB_DUP    = 3'b010,
    JOB_NAK    = 3'b100
  } job_kind_t;

  // One classified packet on its way to the back.
  typedef struct packed {
    job_kind_t                       kind;
    logic [PAYLOAD_LEN-1:0][7:0]     payload;
    logic [31:0]                     reply_seq;
    logic [31:0]                     reply_sum;
  } job_t;

  // Fill status of the job queue.
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

>>> rtl/abr_front.sv
// Front of the receiver: gathers payload bytes, accumulates the checksum and
// classifies each finished packet into a job. Depends on abr_pkg.
module abr_front import abr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [7:0]  payload_byte,
  input  logic signed [31:0] seq_field,
  input  logic signed [31:0] ack_field,
  input  logic signed [31:0] sum_field,
  input  logic               end_of_packet,
  input  q_status_t          q_status,
  output logic               job_push,
  output job_t               job
);

  // Gather stage state.
  logic [POS_W-1:0]            pos;
  logic [31:0]                 running_sum;
  logic [PAYLOAD_LEN-1:0][7:0] pbuf;
  logic [PAYLOAD_LEN-1:0]      pvalid;

  // Finished packet waiting for classification.
  logic                        done_valid;
  logic [PAYLOAD_LEN-1:0][7:0] done_payload;
  logic [31:0]                 done_sum;
  logic [31:0]                 done_hdr;
  logic [31:0]                 done_seq;
  logic [31:0]                 done_seq22;
  logic [31:0]                 done_sumf;
  logic                        done_ack_ok;

  // Classification state.
  logic                        expected_bit;
  logic [PAYLOAD_LEN-1:0][7:0] remembered_payload;
  logic [31:0]                 remembered_sum;

  logic                        accept;
  logic                        last;
  logic [WT_W-1:0]             wt;
  logic signed [PROD_W-1:0]    prod;
  logic [31:0]                 sum_now;
  logic [31:0]                 ack_u;
  logic [31:0]                 seq_u;
  logic [PAYLOAD_LEN-1:0][7:0] merged;
  logic [31:0]                 chk;
  logic                        pass;
  logic                        dup;
  logic                        str_eq;
  logic                        seen_zero;

  // A packet waits in the done registers while the queue is full.
  assign full     = done_valid && q_status.full;
  assign accept   = push && !full;
  assign job_push = done_valid && !q_status.full;

  // Weighted byte contribution and header terms.
  assign wt      = WT_W'(pos) + WT_W'(1);
  assign prod    = $signed(payload_byte) * $signed({1'b0, wt});
  assign sum_now = running_sum + {{(32 - PROD_W){prod[PROD_W-1]}}, prod};
  assign ack_u   = ack_field;
  assign seq_u   = seq_field;
  assign last    = end_of_packet || (pos == POS_W'(PAYLOAD_LEN - 1));

  // Full payload of the packet that ends now; bytes never written read as zero.
  always_comb begin
    for (int i = 0; i < PAYLOAD_LEN; i++) begin
      if (POS_W'(i) == pos) begin
        merged[i] = payload_byte;
      end else if (pvalid[i]) begin
        merged[i] = pbuf[i];
      end else begin
        merged[i] = 8'd0;
      end
    end
  end

  // Gather control.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      running_sum <= '0;
      pvalid      <= '0;
      done_valid  <= 1'b0;
    end else begin
      // A new finished packet refills the done registers as the old one leaves.
      if (accept && last) begin
        done_valid <= 1'b1;
      end else if (job_push) begin
        done_valid <= 1'b0;
      end
      if (accept) begin
        if (last) begin
          pos         <= '0;
          running_sum <= '0;
          pvalid      <= '0;
        end else begin
          pos         <= pos + POS_W'(1);
          running_sum <= sum_now;
          pvalid[pos] <= 1'b1;
        end
      end
    end
  end

  // Gather payload and the snapshot of a finished packet.
  always_ff @(posedge clk) begin
    if (accept) begin
      pbuf[pos] <= payload_byte;
    end
    if (accept && last) begin
      done_payload <= merged;
      done_sum     <= sum_now;
      done_hdr     <= ack_u * ACK_WEIGHT + seq_u * SEQ_WEIGHT;
      done_seq     <= seq_u;
      done_seq22   <= seq_u * SEQ_WEIGHT;
      done_sumf    <= sum_field;
      done_ack_ok  <= (ack_u == 32'(REQUIRED_ACK));
    end
  end

  // String compare against the remembered packet, ending at the first zero byte.
  always_comb begin
    str_eq    = 1'b1;
    seen_zero = 1'b0;
    for (int i = 0; i < PAYLOAD_LEN; i++) begin
      if (!seen_zero && (done_payload[i] != remembered_payload[i])) begin
        str_eq = 1'b0;
      end
      if (done_payload[i] == 8'd0) begin
        seen_zero = 1'b1;
      end
    end
  end

  // Accept and duplicate tests.
  assign chk  = done_sum + done_hdr;
  assign pass = (chk == done_sumf) && (done_seq == {31'd0, expected_bit}) && done_ack_ok;
  assign dup  = str_eq && (done_sumf == remembered_sum);

  // Build the job for the back.
  always_comb begin
    job.payload = done_payload;
    if (pass) begin
      job.kind      = JOB_ACCEPT;
      job.reply_seq = {31'd0, expected_bit};
      job.reply_sum = ONES_PAT_SUM + ACK_WEIGHT + (expected_bit ? SEQ_WEIGHT : 32'd0);
    end else if (dup) begin
      job.kind      = JOB_DUP;
      job.reply_seq = done_seq;
      job.reply_sum = DUP_PAT_SUM + ACK_WEIGHT + done_seq22;
    end else begin
      job.kind      = JOB_NAK;
      job.reply_seq = {31'd0, expected_bit};
      job.reply_sum = ZEROS_PAT_SUM + (expected_bit ? SEQ_WEIGHT : 32'd0);
    end
  end

  // An accepted packet is remembered and flips the expected bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_bit       <= 1'b0;
      remembered_payload <= '0;
      remembered_sum     <= '0;
    end else if (job_push && pass) begin
      expected_bit       <= ~expected_bit;
      remembered_payload <= done_payload;
      remembered_sum     <= done_sumf;
    end
  end

endmodule

>>> rtl/abr_queue.sv
// Short job queue between the front and the back of the receiver.
// Depends on abr_pkg for the job type and the queue depth.
module abr_queue import abr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  job_t      wr_job,
  input  logic      pop,
  output job_t      head,
  output q_status_t status
);

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign status.empty = (count == '0);
  assign status.full  = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (QPTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (QPTR_W + 1)'(1);
      end
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

endmodule

>>> rtl/abr_back.sv
// Back of the receiver: turns queued jobs into result transfers through an
// output register. Depends on abr_pkg.
module abr_back import abr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  job_t               head,
  input  q_status_t          q_status,
  output logic               deq,
  input  logic               pop,
  output logic               empty,
  output logic               kind,
  output logic signed [7:0]  data_byte,
  output logic signed [31:0] reply_seq,
  output logic               reply_ack,
  output logic [1:0]         reply_pattern,
  output logic signed [31:0] reply_sum,
  output logic               final_result
);

  logic            out_valid;
  logic [WT_W-1:0] idx;
  logic            load;
  logic            issue;
  logic            is_byte;
  logic            ack_bit;
  logic [1:0]      pat;

  logic            r_kind;
  logic [7:0]      r_data;
  logic [31:0]     r_seq;
  logic            r_ack;
  logic [1:0]      r_pat;
  logic [31:0]     r_sum;
  logic            r_final;

  // The output register refills when empty or when its result is taken.
  assign load    = !out_valid || pop;
  assign issue   = load && !q_status.empty;
  assign is_byte = (head.kind == JOB_ACCEPT) && (idx < WT_W'(PAYLOAD_LEN));
  assign deq     = issue && !is_byte;

  // Reply header fields by outcome.
  always_comb begin
    case (head.kind)
      JOB_ACCEPT: begin
        ack_bit = 1'b1;
        pat     = PAT_ONES;
      end
      JOB_DUP: begin
        ack_bit = 1'b1;
        pat     = PAT_DUP;
      end
      JOB_NAK: begin
        ack_bit = 1'b0;
        pat     = PAT_ZEROS;
      end
      default: begin
        ack_bit = 1'b0;
        pat     = PAT_ZEROS;
      end
    endcase
  end

  // Sequencing of bytes and reply within one job.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= !q_status.empty;
      if (issue) begin
        idx <= is_byte ? idx + WT_W'(1) : '0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (issue) begin
      if (is_byte) begin
        r_kind  <= KIND_BYTE;
        r_data  <= head.payload[idx[POS_W-1:0]];
        r_seq   <= '0;
        r_ack   <= 1'b0;
        r_pat   <= PAT_ONES;
        r_sum   <= '0;
        r_final <= 1'b0;
      end else begin
        r_kind  <= KIND_REPLY;
        r_data  <= '0;
        r_seq   <= head.reply_seq;
        r_ack   <= ack_bit;
        r_pat   <= pat;
        r_sum   <= head.reply_sum;
        r_final <= 1'b1;
      end
    end
  end

  assign empty         = !out_valid;
  assign kind          = r_kind;
  assign data_byte     = r_data;
  assign reply_seq     = r_seq;
  assign reply_ack     = r_ack;
  assign reply_pattern = r_pat;
  assign reply_sum     = r_sum;
  assign final_result  = r_final;

endmodule

>>> rtl/alternating_bit_receiver_unit.sv
// Top level of the alternating-bit receiver: front, job queue and back.
// Depends on abr_pkg, abr_front, abr_queue, abr_back and the macros header.
//
//   Channel   Handshake       Moves
//   input     push / full     payload_byte, seq_field, ack_field, sum_field, end_of_packet
//   result    pop / empty     kind, data_byte, reply_seq, reply_ack, reply_pattern,
//                             reply_sum, final_result
//
// One payload byte transfer is taken every cycle while full is low; the front's
// byte multiply-add sets this. A finished packet is classified from the done
// registers and queued. An accepted packet gives PAYLOAD_LEN + 1 results at one
// per cycle while pop is high, any other packet one result; the back sets that rate.
// full rises only while a classified packet waits on a full job queue.
// Reset (rst, synchronous) empties the queue and the output register and clears the
// expected bit, the checksum and the remembered packet.
`include "alternating_bit_receiver_unit_macros.svh"
module alternating_bit_receiver_unit import abr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [7:0]  payload_byte,
  input  logic signed [31:0] seq_field,
  input  logic signed [31:0] ack_field,
  input  logic signed [31:0] sum_field,
  input  logic               end_of_packet,
  input  logic               pop,
  output logic               empty,
  output logic               kind,
  output logic signed [7:0]  data_byte,
  output logic signed [31:0] reply_seq,
  output logic               reply_ack,
  output logic [1:0]         reply_pattern,
  output logic signed [31:0] reply_sum,
  output logic               final_result
);

  logic      job_push;
  job_t      job;
  job_t      head;
  q_status_t q_status;
  logic      deq;

  // Byte gathering and packet classification.
  abr_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .payload_byte  (payload_byte),
    .seq_field     (seq_field),
    .ack_field     (ack_field),
    .sum_field     (sum_field),
    .end_of_packet (end_of_packet),
    .q_status      (q_status),
    .job_push      (job_push),
    .job           (job)
  );

  // Jobs between front and back.
  abr_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (job_push),
    .wr_job (job),
    .pop    (deq),
    .head   (head),
    .status (q_status)
  );

  // Result generation.
  abr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_status      (q_status),
    .deq           (deq),
    .pop           (pop),
    .empty         (empty),
    .kind          (kind),
    .data_byte     (data_byte),
    .reply_seq     (reply_seq),
    .reply_ack     (reply_ack),
    .reply_pattern (reply_pattern),
    .reply_sum     (reply_sum),
    .final_result  (final_result)
  );

  // The front only stalls input when a classified packet faces a full queue.
  `ABR_ASSERT_NOW(a_full_needs_jobs, full, !q_status.empty)
  // A byte result is never the last result of its packet.
  `ABR_ASSERT_NOW(a_byte_not_final, !empty && kind == KIND_BYTE, !final_result)
  // Only a NAK carries a zero ack number.
  `ABR_ASSERT_NOW(a_ack_matches_pattern, !empty && kind == KIND_REPLY,
    reply_ack == (reply_pattern != PAT_ZEROS))
  // Taking a non-final result makes the next result of the same packet ready at once.
  `ABR_ASSERT_NEXT(a_packet_unbroken, !empty && pop && !final_result, !empty)

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the alternating-bit receiver unit.
// Depends on abr_pkg and alternating_bit_receiver_unit; runs a directed packet table,
// then random packets, and checks every result transfer against a packet predictor.
module testbench;
  import abr_pkg::*;

  localparam int RANDOM_ITEMS = 500;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_LIMIT = 10;
  localparam int DIRECTED_N   = 8;

  // One result transfer as the unit presents it.
  typedef struct packed {
    logic        is_reply;
    logic [7:0]  data;
    logic [31:0] seq;
    logic        ack;
    logic [1:0]  pat;
    logic [31:0] csum;
    logic        last;
  } rx_result_t;

  // One directed packet: bytes are start_byte + i * byte_step.
  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  byte_step;
    logic [5:0]  len;
    logic        eop_last;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [31:0] chk_sum;
    logic        fix_sum;
    logic        has_reply;
    rx_result_t  reply;
  } stim_row_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic signed [7:0]  payload_byte = '0;
  logic signed [31:0] seq_field = '0;
  logic signed [31:0] ack_field = '0;
  logic signed [31:0] sum_field = '0;
  logic               end_of_packet = 1'b0;
  logic               pop = 1'b0;
  logic               empty;
  logic               kind;
  logic signed [7:0]  data_byte;
  logic signed [31:0] reply_seq;
  logic               reply_ack;
  logic [1:0]         reply_pattern;
  logic signed [31:0] reply_sum;
  logic               final_result;

  alternating_bit_receiver_unit dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .payload_byte  (payload_byte),
    .seq_field     (seq_field),
    .ack_field     (ack_field),
    .sum_field     (sum_field),
    .end_of_packet (end_of_packet),
    .pop           (pop),
    .empty         (empty),
    .kind          (kind),
    .data_byte     (data_byte),
    .reply_seq     (reply_seq),
    .reply_ack     (reply_ack),
    .reply_pattern (reply_pattern),
    .reply_sum     (reply_sum),
    .final_result  (final_result)
  );

  // Predictor state of the receiver.
  logic        rx_bit;
  logic [31:0] rx_sum;
  int          rx_pos;
  logic [7:0]  rx_buf [PAYLOAD_LEN];
  logic [7:0]  kept_buf [PAYLOAD_LEN];
  logic [31:0] kept_sum;
  bit          last_was_accept;

  rx_result_t  expected_rx [$];
  int          fail_count = 0;
  int          sent_count = 0;
  int          stall_cycles = 0;
  bit          calm = 1'b0;
  stim_row_t   directed_rows [DIRECTED_N];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Signed byte weighted by its position plus one, wrapping at 32 bits.
  function automatic logic [31:0] weighted_byte(logic [7:0] b, int pos);
    return {{24{b[7]}}, b} * 32'(pos + 1);
  endfunction

  // Checksum field that makes a packet ending with this byte pass the checksum test.
  function automatic logic [31:0] good_checksum(logic [7:0] b, logic [31:0] seq,
                                                logic [31:0] ack);
    int pos;
    pos = (rx_pos >= PAYLOAD_LEN) ? PAYLOAD_LEN - 1 : rx_pos;
    return rx_sum + weighted_byte(b, pos) + ACK_WEIGHT * ack + SEQ_WEIGHT * seq;
  endfunction

  // Reply header with the checksum of its pattern and header fields.
  function automatic rx_result_t reply_result(logic [31:0] seq, logic ack, logic [1:0] pat);
    rx_result_t  r;
    logic [31:0] base;
    case (pat)
      PAT_ONES: base = ONES_PAT_SUM;
      PAT_DUP:  base = DUP_PAT_SUM;
      default:  base = ZEROS_PAT_SUM;
    endcase
    r = '{is_reply: KIND_REPLY, data: 8'h00, seq: seq, ack: ack, pat: pat,
          csum: base + ACK_WEIGHT * 32'(ack) + SEQ_WEIGHT * seq, last: 1'b1};
    return r;
  endfunction

  function automatic stim_row_t mk_row(logic [7:0] start_byte, logic [7:0] byte_step,
                                       int len, logic eop_last, logic [31:0] seq,
                                       logic [31:0] ack, logic [31:0] chk_sum,
                                       logic fix_sum, logic has_reply, logic [31:0] rseq,
                                       logic rack, logic [1:0] rpat, logic [31:0] rsum);
    stim_row_t row;
    row = '{start_byte: start_byte, byte_step: byte_step, len: 6'(len),
            eop_last: eop_last, seq: seq, ack: ack, chk_sum: chk_sum, fix_sum: fix_sum,
            has_reply: has_reply,
            reply: '{is_reply: KIND_REPLY, data: 8'h00, seq: rseq, ack: rack, pat: rpat,
                     csum: rsum, last: 1'b1}};
    return row;
  endfunction

  // Advance the predictor by one accepted byte and queue the results it causes.
  task automatic predict_byte(logic [7:0] b, logic [31:0] seq, logic [31:0] ack,
                              logic [31:0] csum, logic eop);
    int          pos;
    logic [31:0] chk;
    bit          same;
    bit          stop;
    pos = (rx_pos >= PAYLOAD_LEN) ? PAYLOAD_LEN - 1 : rx_pos;
    rx_buf[pos] = b;
    rx_sum = rx_sum + weighted_byte(b, pos);
    if (!eop && pos + 1 < PAYLOAD_LEN) begin
      rx_pos = pos + 1;
    end else begin
      chk = rx_sum + ACK_WEIGHT * ack + SEQ_WEIGHT * seq;
      // String compare against the remembered payload, stopping at the first zero byte.
      same = 1'b1;
      stop = 1'b0;
      for (int i = 0; i < PAYLOAD_LEN; i++) begin
        if (!stop) begin
          if (rx_buf[i] != kept_buf[i]) begin
            same = 1'b0;
            stop = 1'b1;
          end else if (rx_buf[i] == 8'h00) begin
            stop = 1'b1;
          end
        end
      end
      last_was_accept = (chk == csum) && (seq == 32'(rx_bit)) &&
                        (ack == 32'(REQUIRED_ACK));
      if (last_was_accept) begin
        kept_buf = rx_buf;
        kept_sum = csum;
        for (int i = 0; i < PAYLOAD_LEN; i++) begin
          expected_rx.push_back('{is_reply: KIND_BYTE, data: rx_buf[i], seq: 32'd0,
                                  ack: 1'b0, pat: PAT_ONES, csum: 32'd0, last: 1'b0});
        end
        expected_rx.push_back(reply_result(32'(rx_bit), 1'b1, PAT_ONES));
        rx_bit = ~rx_bit;
      end else if (same && csum == kept_sum) begin
        expected_rx.push_back(reply_result(seq, 1'b1, PAT_DUP));
      end else begin
        expected_rx.push_back(reply_result(32'(rx_bit), 1'b0, PAT_ZEROS));
      end
      rx_sum = '0;
      rx_pos = 0;
      foreach (rx_buf[i]) rx_buf[i] = '0;
    end
  endtask

  // Drive one byte from a falling edge and hold it until the transfer completes.
  task automatic send_byte(logic [7:0] b, logic [31:0] seq, logic [31:0] ack,
                           logic [31:0] csum, logic eop);
    while (!calm && $urandom_range(99) < 35) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push          <= 1'b1;
    payload_byte  <= b;
    seq_field     <= seq;
    ack_field     <= ack;
    sum_field     <= csum;
    end_of_packet <= eop;
    do @(posedge clk); while (full);
    @(negedge clk);
    predict_byte(b, seq, ack, csum, eop);
    sent_count++;
  endtask

  // Send a packet; header fields matter only on its last byte.
  task automatic send_packet(input logic [7:0] bytes_in [$], input logic [31:0] seq,
                             input logic [31:0] ack, input logic [31:0] csum,
                             input bit fix_sum, input logic [31:0] flip,
                             input logic eop_last, output logic [31:0] used_sum);
    used_sum = csum;
    for (int i = 0; i < bytes_in.size(); i++) begin
      if (i == bytes_in.size() - 1) begin
        used_sum = (fix_sum ? good_checksum(bytes_in[i], seq, ack) : csum) ^ flip;
        send_byte(bytes_in[i], seq, ack, used_sum, eop_last);
      end else begin
        send_byte(bytes_in[i], $urandom(), $urandom(), $urandom(), 1'b0);
      end
    end
  endtask

  // Payload byte with extra weight on zero and the extremes.
  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(99);
    if (r < 15) return 8'h00;
    if (r < 20) return 8'h80;
    if (r < 25) return 8'h7f;
    return 8'($urandom());
  endfunction

  // Result side: pop at random, with a calm stretch that never stalls.
  always @(negedge clk) begin
    pop <= !rst && (calm || $urandom_range(99) >= 35);
  end

  // Compare every result transfer with the oldest expected result.
  always @(posedge clk) begin
    rx_result_t got;
    rx_result_t want;
    if (!rst && pop && !empty) begin
      got = '{is_reply: kind, data: data_byte, seq: reply_seq, ack: reply_ack,
              pat: reply_pattern, csum: reply_sum, last: final_result};
      if (expected_rx.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("unexpected kind=%0d data=%02h seq=%08h ack=%0d pat=%0d sum=%08h last=%0d",
                   got.is_reply, got.data, got.seq, got.ack, got.pat, got.csum, got.last);
      end else begin
        want = expected_rx.pop_front();
        if (got.is_reply !== want.is_reply || got.data !== want.data ||
            got.seq !== want.seq || got.ack !== want.ack || got.pat !== want.pat ||
            got.csum !== want.csum || got.last !== want.last) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("expected kind=%0d data=%02h seq=%08h ack=%0d pat=%0d sum=%08h last=%0d",
                     want.is_reply, want.data, want.seq, want.ack, want.pat, want.csum,
                     want.last);
            $display("actual   kind=%0d data=%02h seq=%08h ack=%0d pat=%0d sum=%08h last=%0d",
                     got.is_reply, got.data, got.seq, got.ack, got.pat, got.csum, got.last);
          end
        end
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Stimulus: directed packet table, then random packets.
  initial begin
    logic [7:0]  pkt [$];
    logic [7:0]  saved_pkt [$];
    logic [31:0] saved_seq;
    logic [31:0] saved_sum;
    logic [31:0] p_seq;
    logic [31:0] p_ack;
    logic [31:0] flip;
    logic [31:0] used_sum;
    logic        eop_last;
    stim_row_t   row;
    bit          have_saved;
    bit          pressure_done;
    int          mode;
    int          len;
    int          corrupt;
    int          zero_at;
    int          dir_count;

    rx_bit          = 1'b0;
    rx_sum          = '0;
    rx_pos          = 0;
    kept_sum        = '0;
    last_was_accept = 1'b0;
    foreach (rx_buf[i]) rx_buf[i] = '0;
    foreach (kept_buf[i]) kept_buf[i] = '0;
    have_saved    = 1'b0;
    pressure_done = 1'b0;
    saved_seq     = '0;
    saved_sum     = '0;

    // After reset, a zero byte with a zero checksum field matches the cleared memory.
    directed_rows[0] = mk_row(8'h00, 8'h00, 1, 1'b1, 32'd5, 32'd3, 32'd0, 1'b0, 1'b1,
                              32'd5, 1'b1, PAT_DUP,
                              DUP_PAT_SUM + ACK_WEIGHT + SEQ_WEIGHT * 32'd5);
    // Wrong sequence bit and a checksum that differs from the remembered one.
    directed_rows[1] = mk_row(8'h00, 8'h00, 1, 1'b1, 32'd1, 32'd0, 32'd22, 1'b0, 1'b1,
                              32'd0, 1'b0, PAT_ZEROS, ZEROS_PAT_SUM);
    // Most negative byte, accepted.
    directed_rows[2] = mk_row(8'h80, 8'h00, 1, 1'b1, 32'd0, 32'd0, 32'd0, 1'b1, 1'b0,
                              32'd0, 1'b0, PAT_ONES, 32'd0);
    // Good checksum but a nonzero ack field.
    directed_rows[3] = mk_row(8'h7f, 8'h00, 1, 1'b1, 32'd1, 32'd1, 32'd0, 1'b1, 1'b1,
                              32'd1, 1'b0, PAT_ZEROS, ZEROS_PAT_SUM + SEQ_WEIGHT);
    // Most positive byte, accepted, then sent again as a duplicate.
    directed_rows[4] = mk_row(8'h7f, 8'h00, 1, 1'b1, 32'd1, 32'd0, 32'd0, 1'b1, 1'b0,
                              32'd0, 1'b0, PAT_ONES, 32'd0);
    directed_rows[5] = mk_row(8'h7f, 8'h00, 1, 1'b1, 32'd1, 32'd0, 32'd0, 1'b1, 1'b1,
                              32'd1, 1'b1, PAT_DUP, DUP_PAT_SUM + ACK_WEIGHT + SEQ_WEIGHT);
    // Extreme header fields.
    directed_rows[6] = mk_row(8'h01, 8'h00, 1, 1'b1, 32'h7fff_ffff, 32'h8000_0000,
                              32'hffff_ffff, 1'b0, 1'b1, 32'd0, 1'b0, PAT_ZEROS,
                              ZEROS_PAT_SUM);
    // Full-length packet that ends on its byte count without the end marker.
    directed_rows[7] = mk_row(8'h01, 8'h35, PAYLOAD_LEN, 1'b0, 32'd0, 32'd0, 32'd0, 1'b1,
                              1'b0, 32'd0, 1'b0, PAT_ONES, 32'd0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      pkt.delete();
      for (int i = 0; i < row.len; i++) pkt.push_back(row.start_byte + 8'(i) * row.byte_step);
      send_packet(pkt, row.seq, row.ack, row.chk_sum, row.fix_sum, 32'd0, row.eop_last,
                  used_sum);
      if (row.has_reply) expected_rx[expected_rx.size() - 1] = row.reply;
      if (last_was_accept) begin
        saved_pkt = pkt;
        saved_seq = row.seq;
        saved_sum = used_sum;
        have_saved = 1'b1;
      end
    end
    dir_count = sent_count;

    while (sent_count < dir_count + RANDOM_ITEMS) begin
      calm = (sent_count >= dir_count + 300) && (sent_count < dir_count + 400);

      // Hold the sender off once until every queued result has drained.
      if (!pressure_done && sent_count >= dir_count + 200) begin
        pressure_done = 1'b1;
        push <= 1'b0;
        @(negedge clk);
        while (expected_rx.size() != 0) @(negedge clk);
      end

      mode = $urandom_range(99);
      pkt.delete();
      if (mode >= 45 && mode < 60 && have_saved) begin
        // Resend the last accepted packet, sometimes with bytes changed past its first zero.
        pkt = saved_pkt;
        if ($urandom_range(1)) begin
          zero_at = -1;
          foreach (pkt[i]) if (zero_at < 0 && pkt[i] == 8'h00) zero_at = i;
          if (zero_at >= 0)
            for (int i = zero_at + 1; i < pkt.size(); i++) pkt[i] = 8'($urandom());
        end
        send_packet(pkt, saved_seq, 32'(REQUIRED_ACK), saved_sum, 1'b0, 32'd0, 1'b1,
                    used_sum);
      end else if (mode < 80) begin
        // Well-formed packet, or one with a single field broken.
        len = $urandom_range(PAYLOAD_LEN, 1);
        for (int i = 0; i < len; i++) pkt.push_back(rand_byte());
        eop_last = !(len == PAYLOAD_LEN && $urandom_range(1));
        p_seq   = 32'(rx_bit);
        p_ack   = 32'(REQUIRED_ACK);
        flip    = 32'd0;
        corrupt = (mode >= 60) ? $urandom_range(3, 1) : 0;
        case (corrupt)
          1: flip = 32'd1 << $urandom_range(31);
          2: p_seq = p_seq ^ (32'd1 << $urandom_range(31));
          3: p_ack = p_ack ^ (32'd1 << $urandom_range(31));
          default: ;
        endcase
        send_packet(pkt, p_seq, p_ack, 32'd0, 1'b1, flip, eop_last, used_sum);
        if (last_was_accept) begin
          saved_pkt = pkt;
          saved_seq = p_seq;
          saved_sum = used_sum;
          have_saved = 1'b1;
        end
      end else begin
        // Noise: random bytes, markers and headers, then close any open packet.
        len = $urandom_range(24, 1);
        for (int i = 0; i < len; i++)
          send_byte(8'($urandom()), $urandom(), $urandom(), $urandom(),
                    $urandom_range(99) < 15);
        if (rx_pos != 0) send_byte(8'($urandom()), $urandom(), $urandom(), $urandom(), 1'b1);
      end
    end
    calm = 1'b0;
    push <= 1'b0;

    while (expected_rx.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && expected_rx.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/abr_pkg.sv
rtl/abr_front.sv
rtl/abr_queue.sv
rtl/abr_back.sv
rtl/alternating_bit_receiver_unit.sv
verif/testbench.sv
